### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_DIS(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
    else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

### rtl/core/imuafp_pkg.sv
`default_nettype none
package imuafp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] temperature_centi;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_ANGLE   = 2'd0,
    ST_RATE    = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  // Frame tracker summary seen at the checksum byte.
  typedef struct packed {
    logic short_frm;
    logic sum_ok;
    logic angle_type;
    logic rate_type;
  } frame_info_t;

  localparam logic [7:0]  HDR_BYTE        = 8'h55;
  localparam logic [7:0]  TYPE_ANGLE      = 8'h53;
  localparam logic [7:0]  TYPE_RATE       = 8'h52;
  localparam logic [3:0]  MIN_PRIOR_BYTES = 4'd10;
  localparam logic [3:0]  CNT_MAX         = 4'd15;
  localparam logic [31:0] PI_QUARTER_Q32  = 32'hC90F_DAA2;
  localparam logic [47:0] ANG_ROUND       = 48'h0000_8000_0000;
  localparam logic [22:0] RATE_MUL        = 23'd125;
  localparam logic [22:0] RATE_ROUND      = 23'd64;

endpackage
`default_nettype wire

### rtl/core/imuafp_scale.sv
`default_nettype none
module imuafp_scale
  import imuafp_pkg::*;
(
  input  wire logic [15:0]        raw,
  output      logic signed [15:0] angle,
  output      logic signed [15:0] rate
);

  logic        neg;
  logic [15:0] mag;
  logic [47:0] aprod;
  logic [15:0] aq;
  logic [22:0] rprod;
  logic [15:0] rq;

  // Sign-magnitude scaling so halves round away from zero.
  always_comb begin
    neg   = raw[15];
    mag   = neg ? (16'h0000 - raw) : raw;
    aprod = ({32'h0, mag} * {16'h0, PI_QUARTER_Q32}) + ANG_ROUND;
    aq    = aprod[47:32];
    rprod = ({7'h00, mag} * RATE_MUL) + RATE_ROUND;
    rq    = rprod[22:7];
    angle = $signed(neg ? (16'h0000 - aq) : aq);
    rate  = $signed(neg ? (16'h0000 - rq) : rq);
  end

endmodule
`default_nettype wire

### rtl/core/imuafp_frame.sv
`default_nettype none
module imuafp_frame
  import imuafp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              last,
  input  wire logic [7:0]        rx_byte,
  output      frame_info_t       info,
  output      logic [3:0][15:0]  pairs
);

`include "assert_macros.svh"

  logic [3:0]      cnt_r;
  logic [3:0]      cnt_nxt;
  logic [7:0]      sum_r;
  logic [7:0]      sum_nxt;
  logic            hdr_r;
  logic            hdr_nxt;
  logic [7:0]      type_r;
  logic [7:0]      type_nxt;
  logic [7:0][7:0] pay_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    hdr_nxt  = hdr_r;
    type_nxt = type_r;
    if (step) begin
      if (last) begin
        cnt_nxt  = 4'd0;
        sum_nxt  = 8'd0;
        hdr_nxt  = 1'b0;
        type_nxt = 8'd0;
      end else begin
        if (cnt_r == 4'd0) hdr_nxt = (rx_byte == HDR_BYTE);
        if (cnt_r == 4'd1) type_nxt = rx_byte;
        sum_nxt = sum_r + rx_byte;
        if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      sum_r  <= 8'd0;
      hdr_r  <= 1'b0;
      type_r <= 8'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      hdr_r  <= hdr_nxt;
      type_r <= type_nxt;
    end
  end

  // Payload bytes 2..9 land in slots 0..7; no reset needed.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (step && !last && (cnt_r == 4'(i + 2))) pay_r[i] <= rx_byte;
    end
  end

  always_comb begin
    info.short_frm  = (cnt_r < MIN_PRIOR_BYTES);
    info.sum_ok     = (sum_r == rx_byte);
    info.angle_type = hdr_r && (type_r == TYPE_ANGLE);
    info.rate_type  = hdr_r && (type_r == TYPE_RATE);
    for (int k = 0; k < 4; k++) begin
      pairs[k] = {pay_r[2 * k + 1], pay_r[2 * k]};
    end
  end

  `ASSERT_DIS(a_cnt_clear, clk, rst_n, (step && last) |=> (cnt_r == 4'd0),
    "byte count not cleared after frame end")
  `ASSERT_DIS(a_sum_idle, clk, rst_n, (cnt_r == 4'd0) |-> (sum_r == 8'd0),
    "running sum nonzero at frame start")

endmodule
`default_nettype wire

### rtl/core/imu_attitude_frame_parser_core.sv
`default_nettype none
// A frame_end byte is registered in the input stage; its result is then loaded into the output register.
// Throughput: one byte per cycle; a frame_end byte stalls only while the
//   previous result is still unclaimed in the output register.
// Reset: synchronous active-low rst_n clears frame tracking, held values and
//   valid flags; payload byte storage is not reset.
module imu_attitude_frame_parser_core
  import imuafp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

`include "assert_macros.svh"

  // Input stage register.
  logic     stg_vld_r;
  logic     stg_vld_nxt;
  in_item_t stg_r;
  logic     stg_adv;

  // Result register: the held values double as the output payload, since
  // they only change when a new result is loaded.
  logic               out_vld_r;
  logic               out_vld_nxt;
  status_t            status_r;
  status_t            status_nxt;
  logic signed [15:0] ang_r  [3];
  logic signed [15:0] rate_r [3];
  logic signed [15:0] temp_r;

  frame_info_t        info;
  logic [3:0][15:0]   pairs;
  logic signed [15:0] ang_s  [3];
  logic signed [15:0] rate_s [3];
  logic               fin;
  logic               upd_ang;
  logic               upd_rate;

  // Advance the staged byte: ordinary bytes always retire, the checksum byte
  // waits for room in the result register.
  assign stg_adv  = stg_vld_r && (!stg_r.frame_end || !out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || stg_adv;
  assign fin      = stg_adv && stg_r.frame_end;

  imuafp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (stg_adv),
    .last    (stg_r.frame_end),
    .rx_byte (stg_r.rx_byte),
    .info    (info),
    .pairs   (pairs)
  );

  for (genvar g = 0; g < 3; g++) begin : g_scale
    imuafp_scale u_scale (
      .raw   (pairs[g]),
      .angle (ang_s[g]),
      .rate  (rate_s[g])
    );
  end

  // Decide the frame outcome: short frames reject before the checksum counts.
  always_comb begin
    upd_ang  = 1'b0;
    upd_rate = 1'b0;
    if (info.short_frm) begin
      status_nxt = ST_REJECT;
    end else if (!info.sum_ok) begin
      status_nxt = ST_BAD_SUM;
    end else if (info.angle_type) begin
      status_nxt = ST_ANGLE;
      upd_ang    = fin;
    end else if (info.rate_type) begin
      status_nxt = ST_RATE;
      upd_rate   = fin;
    end else begin
      status_nxt = ST_REJECT;
    end
  end

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_valid && in_ready) begin
      stg_vld_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fin) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg_r <= in_data;
    if (fin) status_r <= status_nxt;
  end

  // Held values persist across frames; reset clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ang_r[i]  <= 16'sd0;
        rate_r[i] <= 16'sd0;
      end
      temp_r <= 16'sd0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (upd_ang)  ang_r[i]  <= ang_s[i];
        if (upd_rate) rate_r[i] <= rate_s[i];
      end
      if (upd_ang || upd_rate) temp_r <= $signed(pairs[3]);
    end
  end

  assign out_valid = out_vld_r;
  always_comb begin
    out_data.frame_status      = status_r;
    out_data.roll_angle        = ang_r[0];
    out_data.pitch_angle       = ang_r[1];
    out_data.yaw_angle         = ang_r[2];
    out_data.roll_rate         = rate_r[0];
    out_data.pitch_rate        = rate_r[1];
    out_data.yaw_rate          = rate_r[2];
    out_data.temperature_centi = temp_r;
  end

  `ASSERT_DIS(a_ang_only_on_angle, clk, rst_n,
    ($past(rst_n) && !$stable(ang_r[0])) |-> $past(upd_ang),
    "held roll angle changed without an angle frame")
  `ASSERT_DIS(a_out_from_end, clk, rst_n,
    ($past(rst_n) && $rose(out_vld_r)) |-> $past(stg_vld_r && stg_r.frame_end),
    "result raised without a frame end byte")
  `ASSERT_DIS(a_upd_exclusive, clk, rst_n, !(upd_ang && upd_rate),
    "angle and rate update in the same frame")

endmodule
`default_nettype wire
